// ----- rtl/core/brnc_pkg.sv -----
// package: constants, codes and types shared by the nvme command builder
package brnc_pkg;

    localparam int CHUNK_PAGES        = 64;
    localparam int PAGE_BYTES         = 4096;
    localparam int MAX_TRANSFER_BYTES = 16777216;
    localparam int RESULT_LIMIT       = 64;
    localparam int CHUNK_BYTES        = CHUNK_PAGES * PAGE_BYTES;

    localparam int SHIFT_MIN = 9;
    localparam int SHIFT_MAX = 16;

    localparam int ALU_W = 49;

    localparam logic [1:0] STATUS_ISSUED     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [1:0] STATUS_MISALIGNED = 2'd2;

    localparam logic [1:0] OPC_NONE  = 2'd0;
    localparam logic [1:0] OPC_WRITE = 2'd1;
    localparam logic [1:0] OPC_READ  = 2'd2;

    localparam logic [2:0] REG_BLOCK_SIZE_LOG2   = 3'd0;
    localparam logic [2:0] REG_PARTITION_BASE    = 3'd1;
    localparam logic [2:0] REG_PARTITION_SIZE    = 3'd2;
    localparam logic [2:0] REG_BOUNCE_ADDRESS    = 3'd3;
    localparam logic [2:0] REG_PAGE_LIST_ADDRESS = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_END,
        ST_CLIP,
        ST_BASE,
        ST_EMIT,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_op_t;

endpackage

// ----- rtl/core/brnc_alu.sv -----
// shared add / subtract unit used by the command sequencer
module brnc_alu (
    input  brnc_pkg::alu_op_t             op,
    output logic [brnc_pkg::ALU_W-1:0]    result
);
    import brnc_pkg::*;

    always_comb begin
        if (op.sub) begin
            result = op.a - op.b;
        end else begin
            result = op.a + op.b;
        end
    end

endmodule

// ----- rtl/core/block_request_to_nvme_commands_top.sv -----
// top level: apb registers, request sequencer and command output register
//
//  channel   dir   handshake          payload
//  s_        in    s_valid/s_ready    s_is_write, s_byte_position, s_total_bytes
//  m_        out   m_valid/m_ready    status, opcode, command id, lba, count, prp, bytes, last
//  apb       in    psel/penable       paddr, pwdata, pwrite, prdata, pready
//
// a request passes four setup steps (check, partition end, clip, base), then issues one command
// per cycle while the output register is free (up to 64), holding s_ready low until it is idle
// a rejected or empty request gives one status beat
// the output register holds a beat while m_ready is low and the sequencer waits
// synchronous active-low reset clears control state, configuration and output valid to defaults
module block_request_to_nvme_commands_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_is_write,
    input  logic [47:0] s_byte_position,
    input  logic [24:0] s_total_bytes,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_opcode,
    output logic [15:0] m_command_id,
    output logic [38:0] m_start_lba,
    output logic [8:0]  m_blocks_minus_one,
    output logic [51:0] m_data_pointer_one,
    output logic [51:0] m_data_pointer_two,
    output logic [18:0] m_chunk_bytes,
    output logic        m_last
);
    import brnc_pkg::*;

    logic [4:0]  block_size_log2_reg;
    logic [47:0] partition_base_reg;
    logic [47:0] partition_size_reg;
    logic [51:0] bounce_address_reg;
    logic [51:0] page_list_address_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;

    state_t      state_reg, state_next;
    logic        write_reg, write_next;
    logic [47:0] pos_reg, pos_next;
    logic [24:0] rem_reg, rem_next;
    logic [4:0]  shift_reg, shift_next;
    logic [47:0] end_reg, end_next;
    logic [48:0] disk_reg, disk_next;
    logic [5:0]  count_reg, count_next;
    logic [15:0] command_counter_reg, command_counter_next;
    logic [1:0]  status_code_reg, status_code_next;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [1:0]  out_opcode_reg;
    logic [15:0] out_command_id_reg;
    logic [38:0] out_start_lba_reg;
    logic [8:0]  out_blocks_reg;
    logic [51:0] out_prp1_reg;
    logic [51:0] out_prp2_reg;
    logic [18:0] out_chunk_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        load_cmd;
    logic        load_status;

    alu_op_t     alu_op;
    logic [48:0] alu_result;

    logic [15:0] bmask;
    logic [16:0] bsize;
    logic [18:0] chunk_limit;
    logic [18:0] chunk;
    logic [24:0] rem_after;
    logic [47:0] end_masked;
    logic [24:0] clip_total;
    logic [48:0] lba_shifted;
    logic [18:0] nblk;
    logic [51:0] prp2;
    logic        cmd_last;
    logic [4:0]  shift_in;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_log2_reg   <= 5'(SHIFT_MIN);
            partition_base_reg    <= '0;
            partition_size_reg    <= '0;
            bounce_address_reg    <= '0;
            page_list_address_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_BLOCK_SIZE_LOG2:   block_size_log2_reg   <= pwdata[4:0];
                REG_PARTITION_BASE:    partition_base_reg    <= pwdata[47:0];
                REG_PARTITION_SIZE:    partition_size_reg    <= pwdata[47:0];
                REG_BOUNCE_ADDRESS:    bounce_address_reg    <= pwdata[51:0];
                REG_PAGE_LIST_ADDRESS: page_list_address_reg <= pwdata[51:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_BLOCK_SIZE_LOG2:   prdata = {59'd0, block_size_log2_reg};
            REG_PARTITION_BASE:    prdata = {16'd0, partition_base_reg};
            REG_PARTITION_SIZE:    prdata = {16'd0, partition_size_reg};
            REG_BOUNCE_ADDRESS:    prdata = {12'd0, bounce_address_reg};
            REG_PAGE_LIST_ADDRESS: prdata = {12'd0, page_list_address_reg};
            default:               prdata = '0;
        endcase
    end

    // block size helpers
    always_comb begin
        if (block_size_log2_reg < 5'(SHIFT_MIN)) begin
            shift_in = 5'(SHIFT_MIN);
        end else if (block_size_log2_reg > 5'(SHIFT_MAX)) begin
            shift_in = 5'(SHIFT_MAX);
        end else begin
            shift_in = block_size_log2_reg;
        end
    end

    assign bsize = 17'd1 << shift_reg;
    assign bmask = 16'(bsize - 17'd1);

    always_comb begin
        chunk_limit = 19'(CHUNK_BYTES) & ~{3'd0, bmask};
        if (chunk_limit == '0) begin
            chunk_limit = 19'(bsize);
        end
    end

    assign chunk      = (rem_reg > {6'd0, chunk_limit}) ? chunk_limit : rem_reg[18:0];
    assign rem_after  = rem_reg - {6'd0, chunk};
    assign end_masked = end_reg & ~{32'd0, bmask};
    assign clip_total = ({23'd0, rem_reg} > end_reg) ? end_masked[24:0] : rem_reg;
    assign lba_shifted = disk_reg >> shift_reg;
    assign nblk        = chunk >> shift_reg;
    assign cmd_last    = (rem_after == '0) || (count_reg == 6'(RESULT_LIMIT - 1));

    always_comb begin
        if (chunk <= 19'(PAGE_BYTES)) begin
            prp2 = '0;
        end else if (chunk <= 19'(2 * PAGE_BYTES)) begin
            prp2 = bounce_address_reg + 52'(PAGE_BYTES);
        end else begin
            prp2 = page_list_address_reg;
        end
    end

    brnc_alu u_alu (
        .op     (alu_op),
        .result (alu_result)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            command_counter_reg <= '0;
            count_reg           <= '0;
        end else begin
            state_reg           <= state_next;
            command_counter_reg <= command_counter_next;
            count_reg           <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        write_reg       <= write_next;
        pos_reg         <= pos_next;
        rem_reg         <= rem_next;
        shift_reg       <= shift_next;
        end_reg         <= end_next;
        disk_reg        <= disk_next;
        status_code_reg <= status_code_next;
    end

    always_comb begin
        state_next           = state_reg;
        write_next           = write_reg;
        pos_next             = pos_reg;
        rem_next             = rem_reg;
        shift_next           = shift_reg;
        end_next             = end_reg;
        disk_next            = disk_reg;
        count_next           = count_reg;
        command_counter_next = command_counter_reg;
        status_code_next     = status_code_reg;
        load_cmd             = 1'b0;
        load_status          = 1'b0;
        alu_op.a             = disk_reg;
        alu_op.b             = {30'd0, chunk};
        alu_op.sub           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    write_next = s_is_write;
                    pos_next   = s_byte_position;
                    rem_next   = s_total_bytes;
                    shift_next = shift_in;
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (rem_reg == '0) begin
                    status_code_next = STATUS_EMPTY;
                    state_next       = ST_STATUS;
                end else if ((pos_reg[15:0] & bmask) != '0 ||
                             (rem_reg[15:0] & bmask) != '0) begin
                    status_code_next = STATUS_MISALIGNED;
                    state_next       = ST_STATUS;
                end else begin
                    if (rem_reg > 25'(MAX_TRANSFER_BYTES)) begin
                        rem_next = 25'(MAX_TRANSFER_BYTES) & ~{9'd0, bmask};
                    end
                    state_next = ST_END;
                end
            end
            ST_END: begin
                alu_op.a   = {1'b0, partition_size_reg};
                alu_op.b   = {1'b0, pos_reg};
                alu_op.sub = 1'b1;
                end_next   = alu_result[47:0];
                if (alu_result[48] || alu_result == '0) begin
                    status_code_next = STATUS_EMPTY;
                    state_next       = ST_STATUS;
                end else begin
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP: begin
                rem_next = clip_total;
                if (clip_total == '0) begin
                    status_code_next = STATUS_EMPTY;
                    state_next       = ST_STATUS;
                end else begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: begin
                alu_op.a   = {1'b0, partition_base_reg};
                alu_op.b   = {1'b0, pos_reg};
                alu_op.sub = 1'b0;
                disk_next  = alu_result;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_cmd             = 1'b1;
                    disk_next            = alu_result;
                    rem_next             = rem_after;
                    count_next           = count_reg + 6'd1;
                    command_counter_next = command_counter_reg + 16'd1;
                    if (cmd_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    load_status = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_cmd || load_status) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_cmd) begin
            out_status_reg     <= STATUS_ISSUED;
            out_opcode_reg     <= write_reg ? OPC_WRITE : OPC_READ;
            out_command_id_reg <= command_counter_reg + 16'd1;
            out_start_lba_reg  <= lba_shifted[38:0];
            out_blocks_reg     <= 9'(nblk - 19'd1);
            out_prp1_reg       <= bounce_address_reg;
            out_prp2_reg       <= prp2;
            out_chunk_reg      <= chunk;
            out_last_reg       <= cmd_last;
        end else if (load_status) begin
            out_status_reg     <= status_code_reg;
            out_opcode_reg     <= OPC_NONE;
            out_command_id_reg <= '0;
            out_start_lba_reg  <= '0;
            out_blocks_reg     <= '0;
            out_prp1_reg       <= '0;
            out_prp2_reg       <= '0;
            out_chunk_reg      <= '0;
            out_last_reg       <= 1'b1;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = out_status_reg;
    assign m_opcode           = out_opcode_reg;
    assign m_command_id       = out_command_id_reg;
    assign m_start_lba        = out_start_lba_reg;
    assign m_blocks_minus_one = out_blocks_reg;
    assign m_data_pointer_one = out_prp1_reg;
    assign m_data_pointer_two = out_prp2_reg;
    assign m_chunk_bytes      = out_chunk_reg;
    assign m_last             = out_last_reg;

endmodule
